/* rtl/core/rotated_dirty_region_tracker_defines.svh */
// Assertion macros shared by the tracker RTL.
`ifndef ROTATED_DIRTY_REGION_TRACKER_DEFINES_SVH
`define ROTATED_DIRTY_REGION_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdrt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RDRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdrt: next-cycle check failed");

`endif

/* rtl/core/rdrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rdrt_pkg;

   // Fixed widths of the stream fields and configuration registers.
   localparam int FieldBits   = 10;
   localparam int DimRegBits  = 11;
   localparam int ModeBits    = 3;
   localparam int CsrIdxBits  = 2;
   localparam int ReqDataBits = 4 * FieldBits;
   localparam int RspDataBits = 4 * FieldBits;

   // Default coordinate space and register reset values.
   localparam int CoordBitsDefault = 10;
   localparam logic [ModeBits-1:0]   ModeReset   = '0;
   localparam logic [DimRegBits-1:0] WidthReset  = DimRegBits'(200);
   localparam logic [DimRegBits-1:0] HeightReset = DimRegBits'(200);

   // Result queue depth; two free entries are needed to process an item.
   localparam int OutDepth   = 4;
   localparam int OutPtrBits = $clog2(OutDepth);
   localparam int OutCntBits = $clog2(OutDepth + 1);

   // Configuration register indexes.
   typedef enum logic [CsrIdxBits-1:0] {
      CSR_ROTATION = 2'd0,
      CSR_WIDTH    = 2'd1,
      CSR_HEIGHT   = 2'd2
   } csr_idx_type;

   // Request kinds and result actions.
   localparam logic REQ_MARK     = 1'b0;
   localparam logic REQ_DISPLAY  = 1'b1;
   localparam logic ACT_FLUSH    = 1'b0;
   localparam logic ACT_REFRESH  = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [FieldBits-1:0] y_final;
      logic [FieldBits-1:0] x_final;
      logic [FieldBits-1:0] y_first;
      logic [FieldBits-1:0] x_first;
   } req_item_type;

   typedef struct packed {
      logic                 action;
      logic                 last;
      logic [FieldBits-1:0] bottom_row;
      logic [FieldBits-1:0] top_row;
      logic [FieldBits-1:0] last_byte_col;
      logic [FieldBits-1:0] left_col;
   } rsp_item_type;

   // Configuration seen by the coordinate mapper.
   typedef struct packed {
      logic [ModeBits-1:0]   rotation_mode;
      logic [DimRegBits-1:0] width_px;
      logic [DimRegBits-1:0] height_px;
   } map_cfg_type;

endpackage

`default_nettype wire

/* rtl/core/rotated_dirty_region_tracker.sv */
// Dirty-region tracker for partial refresh of an e-paper panel.
// The req channel takes one beat per command: tuser 0 marks a drawn rectangle,
// tuser 1 requests a display. The rsp channel returns zero, one or two beats per
// command: tuser 0 flushes the shown region, tuser 1 writes and refreshes the
// pending region; tlast marks the final beat caused by a command.
// The csr channel writes rotation mode (index 0), width (1) and height (2); it is
// always ready and is meant to be written only while the block is idle.
// A command is captured in the input register and is processed from there into
// the result queue once the queue has two free entries; the queue offers its beats.
// Throughput: one command per cycle while the rsp side keeps up. The rsp side
// moves one beat per cycle, so a command with two results holds that side for
// both beats; the four-entry result queue decides when the input stage may drain.
// When the receiver stalls, results stay in the queue and the input register,
// then req_tready, back up once the queue has fewer than two free entries.
// Reset empties the pending and shown regions, the queue and the input register,
// and restores mode 0 and a 200 by 200 panel.
`timescale 1ns / 1ps
`default_nettype none
`include "rotated_dirty_region_tracker_defines.svh"

module rotated_dirty_region_tracker
   import rdrt_pkg::*;
#(
   parameter int CoordBits = CoordBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: x_first, y_first, x_final, y_final
   input  logic [ReqDataBits-1:0] req_tdata,
   // req_tuser: req_type
   input  logic                   req_tuser,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // rsp_tdata: left_col, last_byte_col, top_row, bottom_row
   output logic [RspDataBits-1:0] rsp_tdata,
   // rsp_tuser: action
   output logic                   rsp_tuser,
   output logic                   rsp_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [DimRegBits-1:0]  csr_wdata
);

   // Configuration registers.
   map_cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation_mode <= ModeReset;
         cfg_ff.width_px      <= WidthReset;
         cfg_ff.height_px     <= HeightReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROTATION: cfg_ff.rotation_mode <= csr_wdata[ModeBits-1:0];
            CSR_WIDTH:    cfg_ff.width_px      <= csr_wdata;
            CSR_HEIGHT:   cfg_ff.height_px     <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Input register.
   req_item_type in_item_ff;
   logic         in_vld_ff, in_vld_in;
   logic         proc;
   logic [OutCntBits-1:0] cnt_ff, cnt_in;

   assign proc       = in_vld_ff && (cnt_ff <= OutCntBits'(OutDepth - 2));
   assign req_tready = !in_vld_ff || proc;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !proc);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= {req_tuser, req_tdata};
      end
   end

   // Map the rectangle into panel coordinates.
   logic [CoordBits-1:0] nb_left, nb_right, nb_top, nb_bottom;

   rdrt_map #(
      .CoordBits (CoordBits)
   ) u_map (
      .cfg        (cfg_ff),
      .item       (in_item_ff),
      .box_left   (nb_left),
      .box_right  (nb_right),
      .box_top    (nb_top),
      .box_bottom (nb_bottom)
   );

   // Region state.
   logic [CoordBits-1:0] pend_l_ff, pend_r_ff, pend_t_ff, pend_b_ff;
   logic [CoordBits-1:0] shown_l_ff, shown_r_ff, shown_t_ff, shown_b_ff;
   logic                 pend_vld_ff, shown_vld_ff;
   logic                 is_mark, overlap, flush_en, write_en;

   assign is_mark  = (in_item_ff.kind == REQ_MARK);
   assign overlap  = shown_vld_ff &&
                     (shown_l_ff <= nb_right) && (nb_left <= shown_r_ff) &&
                     (shown_t_ff <= nb_bottom) && (nb_top <= shown_b_ff);
   assign flush_en = is_mark ? overlap : shown_vld_ff;
   assign write_en = !is_mark && pend_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff  <= 1'b0;
         shown_vld_ff <= 1'b0;
      end else if (proc) begin
         if (is_mark) begin
            pend_vld_ff <= 1'b1;
            if (overlap) begin
               shown_vld_ff <= 1'b0;
            end
         end else begin
            pend_vld_ff  <= 1'b0;
            shown_vld_ff <= pend_vld_ff;
         end
      end
   end

   // Box payload needs no reset; the valid bits guard it.
   always_ff @(posedge clock) begin
      if (proc) begin
         if (is_mark) begin
            if (pend_vld_ff) begin
               if (nb_left < pend_l_ff)   pend_l_ff <= nb_left;
               if (nb_right > pend_r_ff)  pend_r_ff <= nb_right;
               if (nb_top < pend_t_ff)    pend_t_ff <= nb_top;
               if (nb_bottom > pend_b_ff) pend_b_ff <= nb_bottom;
            end else begin
               pend_l_ff <= nb_left;
               pend_r_ff <= nb_right;
               pend_t_ff <= nb_top;
               pend_b_ff <= nb_bottom;
            end
         end else if (pend_vld_ff) begin
            shown_l_ff <= pend_l_ff;
            shown_r_ff <= pend_r_ff;
            shown_t_ff <= pend_t_ff;
            shown_b_ff <= pend_b_ff;
         end
      end
   end

   // Build the result beats of this command.
   rsp_item_type flush_item, write_item, slot0, slot1;
   logic [1:0]   npush;

   always_comb begin
      flush_item.action        = ACT_FLUSH;
      flush_item.last          = !write_en;
      flush_item.left_col      = FieldBits'(shown_l_ff);
      flush_item.last_byte_col = FieldBits'({shown_r_ff[CoordBits-1:3], 3'b000});
      flush_item.top_row       = FieldBits'(shown_t_ff);
      flush_item.bottom_row    = FieldBits'(shown_b_ff);
      write_item.action        = ACT_REFRESH;
      write_item.last          = 1'b1;
      write_item.left_col      = FieldBits'(pend_l_ff);
      write_item.last_byte_col = FieldBits'({pend_r_ff[CoordBits-1:3], 3'b000});
      write_item.top_row       = FieldBits'(pend_t_ff);
      write_item.bottom_row    = FieldBits'(pend_b_ff);
      slot0 = flush_en ? flush_item : write_item;
      slot1 = write_item;
      npush = proc ? (2'(flush_en) + 2'(write_en)) : 2'd0;
   end

   // Result queue.
   rsp_item_type           out_mem [OutDepth];
   logic [OutPtrBits-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic                   pop;

   assign rsp_tvalid = (cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign cnt_in     = cnt_ff + OutCntBits'(npush) - OutCntBits'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_ff + OutPtrBits'(npush);
         rd_ptr_ff <= rd_ptr_ff + OutPtrBits'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (npush != 2'd0) begin
         out_mem[wr_ptr_ff] <= slot0;
      end
      if (npush == 2'd2) begin
         out_mem[wr_ptr_ff + OutPtrBits'(1)] <= slot1;
      end
   end

   rsp_item_type head;

   assign head      = out_mem[rd_ptr_ff];
   assign rsp_tdata = {head.bottom_row, head.top_row, head.last_byte_col, head.left_col};
   assign rsp_tuser = head.action;
   assign rsp_tlast = head.last;

   // Checks on the queue and the region state.
   `RDRT_ASSERT_SAME(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= OutCntBits'(OutDepth))
   `RDRT_ASSERT_NEXT(a_held_item, clock, reset, in_vld_ff && !proc, in_vld_ff)
   `RDRT_ASSERT_NEXT(a_mark_pends, clock, reset, proc && is_mark, pend_vld_ff)
   `RDRT_ASSERT_NEXT(a_display_moves, clock, reset, proc && write_en,
                     shown_vld_ff && !pend_vld_ff)

endmodule

`default_nettype wire

/* rtl/core/rdrt_map.sv */
`timescale 1ns / 1ps
`default_nettype none

module rdrt_map
   import rdrt_pkg::*;
#(
   parameter int CoordBits = CoordBitsDefault
) (
   input  map_cfg_type           cfg,
   input  req_item_type          item,
   output logic [CoordBits-1:0]  box_left,
   output logic [CoordBits-1:0]  box_right,
   output logic [CoordBits-1:0]  box_top,
   output logic [CoordBits-1:0]  box_bottom
);

   localparam int DimBits   = (CoordBits + 1 > DimRegBits) ? CoordBits + 1 : DimRegBits;
   localparam int ClampBits = (CoordBits > FieldBits) ? CoordBits : FieldBits;

   logic [DimBits-1:0]   w_ext, h_ext;
   logic [CoordBits-1:0] w_max, h_max;
   logic [FieldBits-1:0] xs_o, xe_o, ys_o, ye_o;
   logic [FieldBits-1:0] ax_xs, ax_xe, ax_ys, ax_ye;
   logic [CoordBits-1:0] xs_c, xe_c, ys_c, ye_c;
   logic [CoordBits-1:0] xs_m, xe_m, ys_m, ye_m;
   logic                 mirror_x, mirror_y;

   // Last valid pixel index per axis: zero acts as one, oversize as full space.
   always_comb begin
      w_ext = DimBits'(cfg.width_px);
      h_ext = DimBits'(cfg.height_px);
      if (w_ext == '0) begin
         w_max = {CoordBits{1'b0}};
      end else if (w_ext > (DimBits'(1) << CoordBits)) begin
         w_max = {CoordBits{1'b1}};
      end else begin
         w_max = CoordBits'(w_ext - DimBits'(1));
      end
      if (h_ext == '0) begin
         h_max = {CoordBits{1'b0}};
      end else if (h_ext > (DimBits'(1) << CoordBits)) begin
         h_max = {CoordBits{1'b1}};
      end else begin
         h_max = CoordBits'(h_ext - DimBits'(1));
      end
   end

   // Put each axis in order, then swap axes in the odd modes.
   always_comb begin
      xs_o = (item.x_first > item.x_final) ? item.x_final : item.x_first;
      xe_o = (item.x_first > item.x_final) ? item.x_first : item.x_final;
      ys_o = (item.y_first > item.y_final) ? item.y_final : item.y_first;
      ye_o = (item.y_first > item.y_final) ? item.y_first : item.y_final;
      ax_xs = cfg.rotation_mode[0] ? ys_o : xs_o;
      ax_xe = cfg.rotation_mode[0] ? ye_o : xe_o;
      ax_ys = cfg.rotation_mode[0] ? xs_o : ys_o;
      ax_ye = cfg.rotation_mode[0] ? xe_o : ye_o;
   end

   // Saturate to the panel edge in panel axes.
   always_comb begin
      xs_c = (ClampBits'(ax_xs) > ClampBits'(w_max)) ? w_max : CoordBits'(ax_xs);
      xe_c = (ClampBits'(ax_xe) > ClampBits'(w_max)) ? w_max : CoordBits'(ax_xe);
      ys_c = (ClampBits'(ax_ys) > ClampBits'(h_max)) ? h_max : CoordBits'(ax_ys);
      ye_c = (ClampBits'(ax_ye) > ClampBits'(h_max)) ? h_max : CoordBits'(ax_ye);
   end

   // Mirror x in modes one, two, six and seven; mirror y in two, three, four and seven.
   always_comb begin
      mirror_x = cfg.rotation_mode[2] ? cfg.rotation_mode[1]
                                      : (cfg.rotation_mode[1] ^ cfg.rotation_mode[0]);
      mirror_y = cfg.rotation_mode[2] ? ~(cfg.rotation_mode[1] ^ cfg.rotation_mode[0])
                                      : cfg.rotation_mode[1];
      xs_m = mirror_x ? (w_max - xe_c) : xs_c;
      xe_m = mirror_x ? (w_max - xs_c) : xe_c;
      ys_m = mirror_y ? (h_max - ye_c) : ys_c;
      ye_m = mirror_y ? (h_max - ys_c) : ye_c;
   end

   // Widen x to whole bytes.
   assign box_left   = {xs_m[CoordBits-1:3], 3'b000};
   assign box_right  = {xe_m[CoordBits-1:3], 3'b111};
   assign box_top    = ys_m;
   assign box_bottom = ye_m;

endmodule

`default_nettype wire
